// ===== sv/pgtw_pkg.sv =====
// Shared widths, register indexes and reset values of the probe grid weight core.
`default_nettype none
package pgtw_pkg;

	localparam int POS_W      = 32;
	localparam int INV_W      = 24;
	localparam int CNT_REG_W  = 30;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IDX_W      = 30;
	localparam int WEIGHT_W   = 37;
	localparam int CORNERS    = 8;
	localparam int CORNER_W   = $clog2(CORNERS);

	// fraction bits of (position difference * reciprocal spacing)
	localparam int SCALE_FRAC = 28;
	// fraction bits of the weight on the result port
	localparam int WEIGHT_FRAC = 36;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_INV_X      = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_INV_Y      = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_INV_Z      = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS     = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_DATA_VALID = CFG_IDX_W'(7);

	localparam logic [INV_W-1:0]     INV_RESET    = INV_W'(65536);
	localparam logic [CNT_REG_W-1:0] COUNTS_RESET = CNT_REG_W'(1049601);

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_NO_DATA = 1'b1;

endpackage
`default_nettype wire

// ===== sv/pgtw_if.sv =====
// Query and result channel interfaces of the probe grid weight core.
`default_nettype none
interface pgtw_query_if;
	logic                           valid;
	logic                           ready;
	logic signed [pgtw_pkg::POS_W-1:0] pos_x;
	logic signed [pgtw_pkg::POS_W-1:0] pos_y;
	logic signed [pgtw_pkg::POS_W-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pgtw_result_if;
	logic                              valid;
	logic                              ready;
	logic [pgtw_pkg::CORNER_W-1:0]     corner;
	logic [pgtw_pkg::IDX_W-1:0]        probe_index;
	logic [pgtw_pkg::WEIGHT_W-1:0]     weight;
	logic                              status;
	logic                              last;

	modport source (output valid, output corner, output probe_index, output weight,
		output status, output last, input ready);
	modport sink   (input valid, input corner, input probe_index, input weight,
		input status, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/probe_grid_trilinear_weights_core.sv =====
// Each corner word passes the stage 1 to stage 5 registers on its way to the result port, and
// the corner words of one query leave in corner order, the eighth marked last.
// Throughput: the corner expander in stage 3 sends one corner a cycle while not stalled,
// and takes no new query until it sends its last corner; a query without probe data gives one word.
// Reset (arst_n low, asynchronous): pipeline empty, corner counter at 0, registers at defaults.
`default_nettype none
module probe_grid_trilinear_weights_core #(
	parameter int COUNT_BITS = 10,
	parameter int FRAC_BITS  = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [pgtw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pgtw_pkg::CFG_DATA_W-1:0]    cfg_data,
	pgtw_query_if.sink                              query,
	pgtw_result_if.source                           result
);

	localparam int POS_W   = pgtw_pkg::POS_W;
	localparam int INV_W   = pgtw_pkg::INV_W;
	localparam int IDX_W   = pgtw_pkg::IDX_W;
	localparam int SHIFT   = pgtw_pkg::SCALE_FRAC - FRAC_BITS;
	localparam int PROD_W  = POS_W + INV_W;
	localparam int GW      = PROD_W - SHIFT;
	localparam int CELL_W  = GW - FRAC_BITS;
	localparam int FW      = FRAC_BITS + 1;
	localparam int CNT_EXT_W = (3 * COUNT_BITS > pgtw_pkg::CNT_REG_W) ?
		3 * COUNT_BITS : pgtw_pkg::CNT_REG_W;
	localparam int WP_W    = 3 * FW;
	localparam int WSH_L   = (3 * FRAC_BITS < pgtw_pkg::WEIGHT_FRAC) ?
		pgtw_pkg::WEIGHT_FRAC - 3 * FRAC_BITS : 0;
	localparam int WSH_R   = (3 * FRAC_BITS > pgtw_pkg::WEIGHT_FRAC) ?
		3 * FRAC_BITS - pgtw_pkg::WEIGHT_FRAC : 0;
	localparam int WX_W    = WP_W + WSH_L;

	// configuration registers
	logic [POS_W-1:0]               origin_q [3];
	logic [INV_W-1:0]               inv_q [3];
	logic [pgtw_pkg::CNT_REG_W-1:0] counts_q;
	logic                           data_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				origin_q[a] <= '0;
				inv_q[a]    <= pgtw_pkg::INV_RESET;
			end
			counts_q     <= pgtw_pkg::COUNTS_RESET;
			data_valid_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pgtw_pkg::REG_ORIGIN_X:   origin_q[0] <= cfg_data;
				pgtw_pkg::REG_ORIGIN_Y:   origin_q[1] <= cfg_data;
				pgtw_pkg::REG_ORIGIN_Z:   origin_q[2] <= cfg_data;
				pgtw_pkg::REG_INV_X:      inv_q[0] <= cfg_data[INV_W-1:0];
				pgtw_pkg::REG_INV_Y:      inv_q[1] <= cfg_data[INV_W-1:0];
				pgtw_pkg::REG_INV_Z:      inv_q[2] <= cfg_data[INV_W-1:0];
				pgtw_pkg::REG_COUNTS:     counts_q <= cfg_data[pgtw_pkg::CNT_REG_W-1:0];
				pgtw_pkg::REG_DATA_VALID: data_valid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per-axis counts, zero read as one
	logic [CNT_EXT_W-1:0]  counts_ext;
	logic [COUNT_BITS-1:0] cnt_raw [3];
	logic [COUNT_BITS-1:0] cnt [3];
	logic [COUNT_BITS-1:0] maxi [3];

	always_comb begin
		counts_ext = CNT_EXT_W'(counts_q);
		for (int a = 0; a < 3; a++) begin
			cnt_raw[a] = counts_ext[a*COUNT_BITS +: COUNT_BITS];
			cnt[a]     = (cnt_raw[a] == '0) ? COUNT_BITS'(1) : cnt_raw[a];
			maxi[a]    = cnt[a] - COUNT_BITS'(1);
		end
	end

	// handshake chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic emit, emit_last;
	logic [pgtw_pkg::CORNER_W-1:0] k_q;
	logic nodata_s1, nodata_s2, nodata_s3;

	assign rdy5      = !v_s5 || result.ready;
	assign rdy4      = !v_s4 || rdy5;
	assign emit      = v_s3 && rdy4;
	assign emit_last = emit && (nodata_s3 ||
		k_q == pgtw_pkg::CORNER_W'(pgtw_pkg::CORNERS - 1));
	assign rdy3      = !v_s3 || emit_last;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign query.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			k_q  <= '0;
		end else begin
			if (rdy1) v_s1 <= query.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (emit) begin
				k_q <= emit_last ? '0 : k_q + pgtw_pkg::CORNER_W'(1);
			end
		end
	end

	// stage 1: subtract origin, clamp negative to zero
	logic [POS_W-1:0] pos_c [3];
	logic [POS_W:0]   diff_c [3];
	logic [POS_W-1:0] mag_c [3];
	logic [POS_W-1:0] mag_s1 [3];

	always_comb begin
		pos_c[0] = query.pos_x;
		pos_c[1] = query.pos_y;
		pos_c[2] = query.pos_z;
		for (int a = 0; a < 3; a++) begin
			diff_c[a] = {pos_c[a][POS_W-1], pos_c[a]} - {origin_q[a][POS_W-1], origin_q[a]};
			mag_c[a]  = (diff_c[a][POS_W] || diff_c[a] == '0) ? '0 : diff_c[a][POS_W-1:0];
		end
	end

	// stage 2: scale by reciprocal spacing
	logic [PROD_W-1:0] prod_c [3];
	logic [GW-1:0]     g_s2 [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod_c[a] = PROD_W'(mag_s1[a]) * PROD_W'(inv_q[a]);
		end
	end

	// stage 3: cell, clamped corners and interpolation factors
	logic [CELL_W-1:0]       cell_c [3];
	logic [COUNT_BITS-1:0]   lo_c [3];
	logic [COUNT_BITS:0]     lo_inc_c [3];
	logic [COUNT_BITS-1:0]   hi_c [3];
	logic [FW-1:0]           f1_c [3];
	logic [FW-1:0]           f0_c [3];
	logic [COUNT_BITS-1:0]   lo_s3 [3];
	logic [COUNT_BITS-1:0]   hi_s3 [3];
	logic [FW-1:0]           f0_s3 [3];
	logic [FW-1:0]           f1_s3 [3];
	logic [2*COUNT_BITS-1:0] xy_s3;
	logic [COUNT_BITS-1:0]   cx_s3;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cell_c[a]   = g_s2[a][GW-1:FRAC_BITS];
			lo_c[a]     = (cell_c[a] < CELL_W'(maxi[a])) ? cell_c[a][COUNT_BITS-1:0] : maxi[a];
			lo_inc_c[a] = {1'b0, lo_c[a]} + (COUNT_BITS+1)'(1);
			hi_c[a]     = (lo_inc_c[a] < {1'b0, maxi[a]}) ?
				lo_inc_c[a][COUNT_BITS-1:0] : maxi[a];
			f1_c[a]     = {1'b0, g_s2[a][FRAC_BITS-1:0]};
			f0_c[a]     = (FW'(1) << FRAC_BITS) - f1_c[a];
		end
	end

	// stage 4: pick one corner a cycle while stage 4 can take it, first products
	logic [COUNT_BITS-1:0]   x_c, y_c, z_c;
	logic [FW-1:0]           wx_c, wy_c, wz_c;
	logic [3*COUNT_BITS-1:0] zxy_full_c;
	logic [pgtw_pkg::CORNER_W-1:0] corner_s4;
	logic [2*FW-1:0]         wxy_s4;
	logic [FW-1:0]           wz_s4;
	logic [IDX_W-1:0]        zxy_s4;
	logic [2*COUNT_BITS-1:0] yx_s4;
	logic [COUNT_BITS-1:0]   x_s4;
	logic                    status_s4, last_s4;

	always_comb begin
		x_c  = k_q[0] ? hi_s3[0] : lo_s3[0];
		y_c  = k_q[1] ? hi_s3[1] : lo_s3[1];
		z_c  = k_q[2] ? hi_s3[2] : lo_s3[2];
		wx_c = k_q[0] ? f1_s3[0] : f0_s3[0];
		wy_c = k_q[1] ? f1_s3[1] : f0_s3[1];
		wz_c = k_q[2] ? f1_s3[2] : f0_s3[2];
		// no grid loaded: drop everything to zero
		if (nodata_s3) begin
			x_c  = '0;
			y_c  = '0;
			z_c  = '0;
			wx_c = '0;
			wy_c = '0;
			wz_c = '0;
		end
		zxy_full_c = (3*COUNT_BITS)'(z_c) * (3*COUNT_BITS)'(xy_s3);
	end

	// stage 5: final weight product, index sum, scale to Q1.36
	logic [WP_W-1:0]                w_full_c;
	logic [WX_W-1:0]                w_ext_c;
	logic [IDX_W-1:0]               idx_c;
	logic [pgtw_pkg::CORNER_W-1:0]  corner_s5;
	logic [IDX_W-1:0]               idx_s5;
	logic [pgtw_pkg::WEIGHT_W-1:0]  weight_s5;
	logic                           status_s5, last_s5;

	always_comb begin
		w_full_c = WP_W'(wxy_s4) * WP_W'(wz_s4);
		w_ext_c  = (WX_W'(w_full_c) << WSH_L) >> WSH_R;
		idx_c    = zxy_s4 + IDX_W'(yx_s4) + IDX_W'(x_s4);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy1 && query.valid) begin
			mag_s1    <= mag_c;
			nodata_s1 <= !data_valid_q;
		end
		if (rdy2 && v_s1) begin
			for (int a = 0; a < 3; a++) begin
				g_s2[a] <= prod_c[a][PROD_W-1:SHIFT];
			end
			nodata_s2 <= nodata_s1;
		end
		if (rdy3 && v_s2) begin
			lo_s3     <= lo_c;
			hi_s3     <= hi_c;
			f0_s3     <= f0_c;
			f1_s3     <= f1_c;
			xy_s3     <= (2*COUNT_BITS)'(cnt[0]) * (2*COUNT_BITS)'(cnt[1]);
			cx_s3     <= cnt[0];
			nodata_s3 <= nodata_s2;
		end
		if (emit) begin
			corner_s4 <= k_q;
			wxy_s4    <= (2*FW)'(wx_c) * (2*FW)'(wy_c);
			wz_s4     <= wz_c;
			zxy_s4    <= IDX_W'(zxy_full_c);
			yx_s4     <= (2*COUNT_BITS)'(y_c) * (2*COUNT_BITS)'(cx_s3);
			x_s4      <= x_c;
			status_s4 <= nodata_s3 ? pgtw_pkg::STATUS_NO_DATA : pgtw_pkg::STATUS_OK;
			last_s4   <= emit_last;
		end
		if (rdy5 && v_s4) begin
			corner_s5 <= corner_s4;
			idx_s5    <= idx_c;
			weight_s5 <= pgtw_pkg::WEIGHT_W'(w_ext_c);
			status_s5 <= status_s4;
			last_s5   <= last_s4;
		end
	end

	assign result.valid       = v_s5;
	assign result.corner      = corner_s5;
	assign result.probe_index = idx_s5;
	assign result.weight      = weight_s5;
	assign result.status      = status_s5;
	assign result.last        = last_s5;

`ifndef SYNTHESIS
	a_ok_last_is_top_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == pgtw_pkg::STATUS_OK && result.last) |->
		(result.corner == pgtw_pkg::CORNER_W'(pgtw_pkg::CORNERS - 1)))
		else $error("ok query ended on a corner other than the last");

	a_nodata_single_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == pgtw_pkg::STATUS_NO_DATA) |->
		(result.last && result.weight == '0 && result.probe_index == '0 &&
		result.corner == '0))
		else $error("no-data word is not a single zero word");

	a_counter_idle_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != '0) |-> v_s3)
		else $error("corner counter advanced with no query in the expander");

	a_nodata_one_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && nodata_s3) |-> (k_q == '0))
		else $error("no-data query expanded past its first word");
`endif

endmodule
`default_nettype wire

// ===== test/probe_grid_trilinear_weights_core_test.sv =====
// Self-checking testbench of the probe grid trilinear weight core: directed script, then random phases.
`timescale 1ns / 100ps
module probe_grid_trilinear_weights_core_test;

	localparam int COUNT_BITS   = 10;
	localparam int FRAC_BITS    = 12;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 44;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 8;
	localparam int DRAIN_CYCLES = 24;
	localparam int LIMIT        = 1000000;

	typedef struct packed {
		logic [pgtw_pkg::CORNER_W-1:0] corner;
		logic [pgtw_pkg::IDX_W-1:0]    probe_index;
		logic [pgtw_pkg::WEIGHT_W-1:0] weight;
		logic                          status;
		logic                          last;
	} corner_word_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_LOOKUP, ROW_NO_DATA} row_kind_t;

	typedef struct {
		row_kind_t                          kind;
		logic [pgtw_pkg::CFG_IDX_W-1:0]     reg_idx;
		logic [pgtw_pkg::CFG_DATA_W-1:0]    data;
		logic signed [pgtw_pkg::POS_W-1:0]  px;
		logic signed [pgtw_pkg::POS_W-1:0]  py;
		logic signed [pgtw_pkg::POS_W-1:0]  pz;
	} script_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pgtw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pgtw_pkg::CFG_DATA_W-1:0] cfg_data;

	pgtw_query_if  query_ch();
	pgtw_result_if result_ch();

	probe_grid_trilinear_weights_core #(
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.query(query_ch),
		.result(result_ch)
	);

	// shadow of the register file
	logic signed [pgtw_pkg::POS_W-1:0] grid_origin [3];
	logic [pgtw_pkg::INV_W-1:0]        grid_scale [3];
	logic [pgtw_pkg::CNT_REG_W-1:0]    grid_counts;
	logic                              grid_loaded;

	corner_word_t  pending_words[$];
	script_row_t   script[$];
	int unsigned   mismatches;
	int unsigned   cycles;
	int unsigned   rx_hold;
	int unsigned   rx_gap;
	bit            rx_stalls;
	bit            tx_gaps;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint unsigned grid_coord(logic signed [pgtw_pkg::POS_W-1:0] p,
			logic signed [pgtw_pkg::POS_W-1:0] o, logic [pgtw_pkg::INV_W-1:0] s);
		longint diff;
		diff = longint'(p) - longint'(o);
		if (diff <= 0)
			return 0;
		return (longint'(diff) * longint'(s)) >> (pgtw_pkg::SCALE_FRAC - FRAC_BITS);
	endfunction

	function automatic longint unsigned axis_count(int a);
		longint unsigned n;
		n = longint'(grid_counts[a*COUNT_BITS +: COUNT_BITS]);
		return (n == 0) ? 1 : n;
	endfunction

	function automatic void push_no_data();
		corner_word_t w;
		w.corner      = '0;
		w.probe_index = '0;
		w.weight      = '0;
		w.status      = pgtw_pkg::STATUS_NO_DATA;
		w.last        = 1'b1;
		pending_words.push_back(w);
	endfunction

	// eight corner words of one lookup, or the no-data word
	function automatic void predict_lookup(logic signed [pgtw_pkg::POS_W-1:0] px,
			logic signed [pgtw_pkg::POS_W-1:0] py, logic signed [pgtw_pkg::POS_W-1:0] pz);
		corner_word_t                      w;
		logic signed [pgtw_pkg::POS_W-1:0] p [3];
		longint unsigned                   g [3];
		longint unsigned                   n [3];
		longint unsigned                   lo [3];
		longint unsigned                   hi [3];
		longint unsigned                   f1 [3];
		longint unsigned                   f0 [3];
		longint unsigned                   lo_raw, top, xi, yi, zi, wt;
		int                                a, k;
		if (!grid_loaded) begin
			push_no_data();
			return;
		end
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		for (a = 0; a < 3; a++) begin
			g[a] = grid_coord(p[a], grid_origin[a], grid_scale[a]);
			lo_raw = g[a] >> FRAC_BITS;
			n[a] = axis_count(a);
			top = n[a] - 1;
			lo[a] = (lo_raw < top) ? lo_raw : top;
			hi[a] = (lo[a] + 1 < top) ? lo[a] + 1 : top;
			f1[a] = g[a] & ((64'd1 << FRAC_BITS) - 1);
			f0[a] = (64'd1 << FRAC_BITS) - f1[a];
		end
		for (k = 0; k < pgtw_pkg::CORNERS; k++) begin
			xi = k[0] ? hi[0] : lo[0];
			yi = k[1] ? hi[1] : lo[1];
			zi = k[2] ? hi[2] : lo[2];
			wt = (k[0] ? f1[0] : f0[0]) * (k[1] ? f1[1] : f0[1]) * (k[2] ? f1[2] : f0[2]);
			if (3 * FRAC_BITS < pgtw_pkg::WEIGHT_FRAC)
				wt = wt << (pgtw_pkg::WEIGHT_FRAC - 3 * FRAC_BITS);
			else
				wt = wt >> (3 * FRAC_BITS - pgtw_pkg::WEIGHT_FRAC);
			w.corner      = pgtw_pkg::CORNER_W'(k);
			w.probe_index = pgtw_pkg::IDX_W'(zi * n[0] * n[1] + yi * n[0] + xi);
			w.weight      = pgtw_pkg::WEIGHT_W'(wt);
			w.status      = pgtw_pkg::STATUS_OK;
			w.last        = (k == pgtw_pkg::CORNERS - 1);
			pending_words.push_back(w);
		end
	endfunction

	// position that lands near the grid along one axis
	function automatic logic signed [pgtw_pkg::POS_W-1:0] aim_axis(int a);
		longint tg, d;
		tg = longint'($urandom_range(0, (axis_count(a) + 2) * 4096)) - 4096;
		if ($urandom_range(0, 9) == 0)
			tg = (tg >>> FRAC_BITS) << FRAC_BITS;
		if (grid_scale[a] == 0)
			d = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
		else
			d = (tg * 65536) / longint'(grid_scale[a]);
		return pgtw_pkg::POS_W'(longint'(grid_origin[a]) + d);
	endfunction

	task automatic write_reg(logic [pgtw_pkg::CFG_IDX_W-1:0] idx,
			logic [pgtw_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			pgtw_pkg::REG_ORIGIN_X: grid_origin[0] = data;
			pgtw_pkg::REG_ORIGIN_Y: grid_origin[1] = data;
			pgtw_pkg::REG_ORIGIN_Z: grid_origin[2] = data;
			pgtw_pkg::REG_INV_X: grid_scale[0] = data[pgtw_pkg::INV_W-1:0];
			pgtw_pkg::REG_INV_Y: grid_scale[1] = data[pgtw_pkg::INV_W-1:0];
			pgtw_pkg::REG_INV_Z: grid_scale[2] = data[pgtw_pkg::INV_W-1:0];
			pgtw_pkg::REG_COUNTS: grid_counts = data[pgtw_pkg::CNT_REG_W-1:0];
			pgtw_pkg::REG_DATA_VALID: grid_loaded = data[0];
			default: ;
		endcase
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		query_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_query(logic signed [pgtw_pkg::POS_W-1:0] px,
			logic signed [pgtw_pkg::POS_W-1:0] py,
			logic signed [pgtw_pkg::POS_W-1:0] pz, bit typed_no_data);
		int unsigned gap;
		gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap != 0) begin
			query_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query_ch.valid <= 1'b1;
		query_ch.pos_x <= px;
		query_ch.pos_y <= py;
		query_ch.pos_z <= pz;
		do @(negedge clk); while (!query_ch.ready);
		@(posedge clk);
		if (typed_no_data)
			push_no_data();
		else
			predict_lookup(px, py, pz);
	endtask

	function automatic void add_write(logic [pgtw_pkg::CFG_IDX_W-1:0] idx,
			logic [pgtw_pkg::CFG_DATA_W-1:0] data);
		script_row_t r;
		r.kind    = ROW_WRITE;
		r.reg_idx = idx;
		r.data    = data;
		r.px      = '0;
		r.py      = '0;
		r.pz      = '0;
		script.push_back(r);
	endfunction

	function automatic void add_query(row_kind_t kind, logic [pgtw_pkg::POS_W-1:0] px,
			logic [pgtw_pkg::POS_W-1:0] py, logic [pgtw_pkg::POS_W-1:0] pz);
		script_row_t r;
		r.kind    = kind;
		r.reg_idx = '0;
		r.data    = '0;
		r.px      = px;
		r.py      = py;
		r.pz      = pz;
		script.push_back(r);
	endfunction

	task automatic program_phase(int ph);
		int unsigned r;
		int          a;
		logic [pgtw_pkg::CNT_REG_W-1:0]  counts;
		logic [pgtw_pkg::CFG_DATA_W-1:0] val;
		wait_idle();
		for (a = 0; a < 3; a++) begin
			r = $urandom_range(0, 9);
			if (ph == 2)
				val = 32'h8000_0000;
			else if (ph == 5)
				val = 32'h7FFF_FFFF;
			else if (r < 2)
				val = $urandom;
			else
				val = pgtw_pkg::CFG_DATA_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			write_reg(pgtw_pkg::REG_ORIGIN_X + pgtw_pkg::CFG_IDX_W'(a), val);
		end
		for (a = 0; a < 3; a++) begin
			r = $urandom_range(0, 9);
			if (ph == 2)
				val = 32'h00FF_FFFF;
			else if (ph == 5)
				val = 32'd1;
			else if (r == 0)
				val = 32'd65536;
			else if (r == 1)
				val = 32'd32768;
			else if (r == 2)
				val = 32'd131072;
			else if (r == 3)
				val = $urandom_range(0, 24'hFF_FFFF);
			else
				val = $urandom_range(4096, 262144);
			write_reg(pgtw_pkg::REG_INV_X + pgtw_pkg::CFG_IDX_W'(a), val);
		end
		for (a = 0; a < 3; a++) begin
			r = $urandom_range(0, 9);
			if (ph == 2)
				counts[a*COUNT_BITS +: COUNT_BITS] = '1;
			else if (r == 0)
				counts[a*COUNT_BITS +: COUNT_BITS] = '0;
			else if (r == 1)
				counts[a*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'($urandom_range(1, 1023));
			else
				counts[a*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'($urandom_range(1, 12));
		end
		write_reg(pgtw_pkg::REG_COUNTS, pgtw_pkg::CFG_DATA_W'(counts));
		write_reg(pgtw_pkg::REG_DATA_VALID, (ph == 4) ? 32'd0 : 32'd1);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, and one long hold-off on request
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			result_ch.ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else if (rx_gap != 0) begin
			result_ch.ready <= 1'b0;
			rx_gap = rx_gap - 1;
		end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
			result_ch.ready <= 1'b0;
			rx_gap = pick_gap() - 1;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// handshake values are stable from the falling edge to the next rising edge
	always @(negedge clk) begin
		corner_word_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_words.size() == 0) begin
				$error("result word with no lookup pending: corner %0d index %0d",
					result_ch.corner, result_ch.probe_index);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (result_ch.corner !== want.corner) begin
					$error("corner: expected %0d, got %0d", want.corner, result_ch.corner);
					mismatches++;
				end
				if (result_ch.probe_index !== want.probe_index) begin
					$error("probe_index: expected %0d, got %0d", want.probe_index,
						result_ch.probe_index);
					mismatches++;
				end
				if (result_ch.weight !== want.weight) begin
					$error("weight: expected %0d, got %0d", want.weight, result_ch.weight);
					mismatches++;
				end
				if (result_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_ch.status);
					mismatches++;
				end
				if (result_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result_ch.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		script_row_t row;
		bit          writing;
		int          ph, i;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		query_ch.valid  = 1'b0;
		query_ch.pos_x  = '0;
		query_ch.pos_y  = '0;
		query_ch.pos_z  = '0;
		rx_hold         = 0;
		rx_gap          = 0;
		rx_stalls       = 1'b1;
		tx_gaps         = 1'b1;
		writing         = 1'b0;
		grid_origin[0]  = '0;
		grid_origin[1]  = '0;
		grid_origin[2]  = '0;
		grid_scale[0]   = pgtw_pkg::INV_RESET;
		grid_scale[1]   = pgtw_pkg::INV_RESET;
		grid_scale[2]   = pgtw_pkg::INV_RESET;
		grid_counts     = pgtw_pkg::COUNTS_RESET;
		grid_loaded     = 1'b0;

		// nothing loaded after reset
		add_query(ROW_NO_DATA, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		add_query(ROW_NO_DATA, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		add_query(ROW_NO_DATA, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		add_write(pgtw_pkg::REG_DATA_VALID, 32'd1);
		// single-probe grid: every corner folds onto index 0
		add_query(ROW_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		add_query(ROW_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_query(ROW_LOOKUP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_query(ROW_LOOKUP, 32'h0000_07FF, 32'h0000_0800, 32'h0000_0FFF);
		// largest grid, widest and zero scale
		add_write(pgtw_pkg::REG_COUNTS, 32'h3FFF_FFFF);
		add_write(pgtw_pkg::REG_INV_X, 32'h00FF_FFFF);
		add_write(pgtw_pkg::REG_INV_Y, 32'd0);
		add_write(pgtw_pkg::REG_INV_Z, 32'd65536);
		add_query(ROW_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_query(ROW_LOOKUP, 32'h0000_1800, 32'h0000_2800, 32'h0000_3FFF);
		add_query(ROW_LOOKUP, 32'h0000_0001, 32'h0000_0000, 32'h003F_F000);
		// origins at the ends of the range: differences at the edge of 33 bits
		add_write(pgtw_pkg::REG_ORIGIN_X, 32'h7FFF_FFFF);
		add_write(pgtw_pkg::REG_ORIGIN_Y, 32'h8000_0000);
		add_write(pgtw_pkg::REG_ORIGIN_Z, 32'h0000_1000);
		add_write(pgtw_pkg::REG_INV_X, 32'd65536);
		add_write(pgtw_pkg::REG_INV_Y, 32'd65536);
		add_query(ROW_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
		add_query(ROW_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000);
		add_query(ROW_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0800, 32'h0000_1800);
		// zero counts act as one probe per axis
		add_write(pgtw_pkg::REG_COUNTS, 32'd0);
		add_query(ROW_LOOKUP, 32'h0000_5800, 32'h0000_6800, 32'h0000_7800);
		// small uneven grid, mixed spacings
		add_write(pgtw_pkg::REG_COUNTS, (32'd2 << 20) | (32'd7 << 10) | 32'd5);
		add_write(pgtw_pkg::REG_ORIGIN_X, 32'hFFFF_F000);
		add_write(pgtw_pkg::REG_ORIGIN_Y, 32'd0);
		add_write(pgtw_pkg::REG_ORIGIN_Z, 32'd0);
		add_write(pgtw_pkg::REG_INV_X, 32'd32768);
		add_write(pgtw_pkg::REG_INV_Y, 32'd131072);
		add_write(pgtw_pkg::REG_INV_Z, 32'd65536);
		add_query(ROW_LOOKUP, 32'h0000_3000, 32'h0000_1400, 32'h0000_0800);
		add_query(ROW_LOOKUP, 32'h0000_8000, 32'h0000_2C00, 32'h0000_1FFF);
		add_query(ROW_LOOKUP, 32'h0000_9800, 32'h0000_3000, 32'h0000_2000);
		add_write(pgtw_pkg::REG_DATA_VALID, 32'd0);
		add_query(ROW_NO_DATA, 32'h0000_1234, 32'h0000_5678, 32'h0000_9ABC);
		add_write(pgtw_pkg::REG_DATA_VALID, 32'd1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[n]) begin
			row = script[n];
			if (row.kind == ROW_WRITE) begin
				if (!writing)
					wait_idle();
				write_reg(row.reg_idx, row.data);
				writing = 1'b1;
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
				end
				send_query(row.px, row.py, row.pz, row.kind == ROW_NO_DATA);
			end
		end
		if (writing)
			cfg_we <= 1'b0;

		for (ph = 0; ph < PHASES; ph++) begin
			program_phase(ph);
			tx_gaps   = (ph % 3 != 1);
			rx_stalls = (ph % 3 != 2);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// stall the result side long enough to back up the query side
				if (ph == 1 && i == 10)
					rx_hold = HOLD_CYCLES;
				// let the pipeline run dry before going on
				if (ph == 3 && i == 20)
					wait_idle();
				if ($urandom_range(0, 3) == 0)
					send_query($urandom, $urandom, $urandom, 1'b0);
				else
					send_query(aim_axis(0), aim_axis(1), aim_axis(2), 1'b0);
			end
		end

		query_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pgtw_pkg.sv
sv/pgtw_if.sv
sv/probe_grid_trilinear_weights_core.sv
test/probe_grid_trilinear_weights_core_test.sv
